[sv/rtm_pkg.sv]
// Shared constants and types for the Reinhard tone map pixel unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package rtm_pkg;

  localparam int CHAN_W             = 8;
  localparam int GAIN_W             = 24;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // Quotient is always below 255, so 8 bits; two bits are resolved per stage.
  localparam int Q_BITS         = 8;
  localparam int DIV_BITS_PER   = 2;
  localparam int DIV_STAGES     = Q_BITS / DIV_BITS_PER;
  // Multiply stage, numerator/denominator stage, then the division stages.
  localparam int PIPE_STAGES    = DIV_STAGES + 2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    REG_TONE_MAP_ENABLE = 1'b0,
    REG_EXPOSURE_GAIN   = 1'b1
  } reg_idx_t;

  typedef logic [PIPE_STAGES-1:0] stage_vec_t;

endpackage

[sv/rtm_in_if.sv]
// Input pixel channel: valid/ready handshake with the ARGB payload.
// Depends on rtm_pkg.
`timescale 1ns / 1ps

interface rtm_in_if import rtm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;
  logic [CHAN_W-1:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

[sv/rtm_out_if.sv]
// Result pixel channel: valid/ready handshake with the ARGB payload.
// Depends on rtm_pkg.
`timescale 1ns / 1ps

interface rtm_out_if import rtm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic [CHAN_W-1:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

[sv/rtm_chan_pipe.sv]
// Datapath for one color channel: multiply by gain, build numerator and
// denominator, then a restoring divider two quotient bits per stage. Uses rtm_pkg.
`timescale 1ns / 1ps

module rtm_chan_pipe import rtm_pkg::*; #(
  parameter int GainFracBits = GAIN_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  stage_vec_t        adv,
  input  logic              tm_en,
  input  logic [GAIN_W-1:0] gain,
  input  logic [CHAN_W-1:0] c_in,
  output logic [CHAN_W-1:0] c_out
);

  localparam int CG_W  = CHAN_W + GAIN_W;
  localparam int K_W   = 8 + GainFracBits;
  localparam int DEN_W = ((CG_W > K_W) ? CG_W : K_W) + 1;
  localparam int REM_W = DEN_W + Q_BITS;

  logic [CG_W-1:0]   cg_r;
  logic [CHAN_W-1:0] ch_r  [PIPE_STAGES];
  // Index 0 holds the numerator/denominator stage, index j+1 the output of divide stage j.
  logic [REM_W-1:0]  rem_r [DIV_STAGES];
  logic [DEN_W-1:0]  den_r [DIV_STAGES];
  logic [Q_BITS-1:0] q_r   [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cg_r     <= CG_W'(c_in) * CG_W'(gain);
      ch_r[0]  <= c_in;
    end
    if (adv[1]) begin
      // 255*cg as a shift and subtract
      rem_r[0] <= REM_W'({cg_r, 8'b0}) - REM_W'(cg_r);
      den_r[0] <= DEN_W'(cg_r) + (DEN_W'(255) << GainFracBits);
      ch_r[1]  <= ch_r[0];
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [REM_W-1:0]  rem_nxt;
    logic [Q_BITS-1:0] q_nxt;

    always_comb begin
      logic [REM_W-1:0] trial;
      rem_nxt = rem_r[j];
      q_nxt   = (j == 0) ? '0 : q_r[(j == 0) ? 0 : j - 1];
      for (int k = 0; k < DIV_BITS_PER; k++) begin
        trial = REM_W'(den_r[j]) << (Q_BITS - 1 - j * DIV_BITS_PER - k);
        if (rem_nxt >= trial) begin
          rem_nxt = rem_nxt - trial;
          q_nxt   = {q_nxt[Q_BITS-2:0], 1'b1};
        end else begin
          q_nxt   = {q_nxt[Q_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j+2]) begin
        q_r[j]    <= q_nxt;
        ch_r[j+2] <= ch_r[j+1];
      end
    end

    if (j < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv[j+2]) begin
          rem_r[j+1] <= rem_nxt;
          den_r[j+1] <= den_r[j];
        end
      end
    end
  end

  assign c_out = tm_en ? q_r[DIV_STAGES-1] : ch_r[PIPE_STAGES-1];

endmodule

[sv/reinhard_tone_map_pixel_unit.sv]
// Top level of the Reinhard tone map pixel unit: APB registers, stage control,
// three channel datapaths and the alpha delay line. Uses rtm_pkg, rtm_in_if, rtm_out_if.
`timescale 1ns / 1ps

// Channel   Kind            Payload
// in_ch     valid/ready in  red_in, green_in, blue_in, alpha_in (8 bits each)
// out_ch    valid/ready out red_out, green_out, blue_out, alpha_out (8 bits each)
// APB       register write  tone_map_enable at 0x0, exposure_gain at 0x4
//
// One pixel per clock while out_ch is ready. The stages are a multiply stage, a
// numerator/denominator stage and four restoring-division stages of two
// quotient bits each. Each stage has its own valid bit and takes new data
// whenever it is empty or its successor moves, so bubbles close up under
// stall and nothing is dropped or repeated. Reset (rst_n, synchronous) clears
// the valid bits and loads the registers with enable 0 and gain 1.0.

module reinhard_tone_map_pixel_unit import rtm_pkg::*; #(
  parameter int GainFracBits = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rtm_in_if.sink                in_ch,
  rtm_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic              tm_en_r;
  logic [GAIN_W-1:0] gain_r;
  reg_idx_t          reg_sel;
  stage_vec_t        vld_r;
  stage_vec_t        adv;
  logic [CHAN_W-1:0] alpha_r [PIPE_STAGES];

  // Register file
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tm_en_r <= 1'b0;
      gain_r  <= GAIN_W'(1) << GainFracBits;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_TONE_MAP_ENABLE: tm_en_r <= pwdata[0];
        REG_EXPOSURE_GAIN:   gain_r  <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TONE_MAP_ENABLE: prdata = APB_DATA_W'(tm_en_r);
      REG_EXPOSURE_GAIN:   prdata = APB_DATA_W'(gain_r);
      default:             prdata = '0;
    endcase
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv[PIPE_STAGES-1] = !vld_r[PIPE_STAGES-1] || out_ch.ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) alpha_r[0] <= in_ch.alpha_in;
    for (int k = 1; k < PIPE_STAGES; k++) begin
      if (adv[k]) alpha_r[k] <= alpha_r[k-1];
    end
  end

  rtm_chan_pipe #(.GainFracBits(GainFracBits)) u_red (
    .clk   (clk),
    .adv   (adv),
    .tm_en (tm_en_r),
    .gain  (gain_r),
    .c_in  (in_ch.red_in),
    .c_out (out_ch.red_out)
  );

  rtm_chan_pipe #(.GainFracBits(GainFracBits)) u_green (
    .clk   (clk),
    .adv   (adv),
    .tm_en (tm_en_r),
    .gain  (gain_r),
    .c_in  (in_ch.green_in),
    .c_out (out_ch.green_out)
  );

  rtm_chan_pipe #(.GainFracBits(GainFracBits)) u_blue (
    .clk   (clk),
    .adv   (adv),
    .tm_en (tm_en_r),
    .gain  (gain_r),
    .c_in  (in_ch.blue_in),
    .c_out (out_ch.blue_out)
  );

  assign out_ch.valid     = vld_r[PIPE_STAGES-1];
  assign out_ch.alpha_out = alpha_r[PIPE_STAGES-1];

endmodule
